// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hdl/kvs_pkg.sv
// Types, opcodes and key normalisation for the keyed value store
package kvs_pkg;

    localparam int unsigned KEY_MAX_BYTES = 20;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [31:0] hi;
        logic [63:0] mid;
        logic [63:0] lo;
    } t_key;

    typedef struct packed {
        logic               opcode;
        logic [63:0]        key_bytes_low;
        logic [63:0]        key_bytes_mid;
        logic [31:0]        key_bytes_high;
        logic signed [63:0] store_value;
    } t_in_item;

    typedef struct packed {
        logic               success;
        logic signed [63:0] read_value;
    } t_out_item;

    // Request travelling down the cell chain
    typedef struct packed {
        logic               op;
        logic               done;
        logic               ok;
        t_key               key;
        logic signed [63:0] data;
    } t_token;

    // Cut the key at its first zero byte and at nbytes
    function automatic t_key normalize_key(t_key k, int unsigned nbytes);
        logic [8*KEY_MAX_BYTES-1:0] flat;
        logic                       ended;
        t_key                       res;
        flat  = {k.hi, k.mid, k.lo};
        ended = 1'b0;
        for (int unsigned i = 0; i < KEY_MAX_BYTES; i++) begin
            if (i >= nbytes || flat[8*i +: 8] == 8'h00) begin
                ended = 1'b1;
            end
            if (ended) begin
                flat[8*i +: 8] = 8'h00;
            end
        end
        res.lo  = flat[63:0];
        res.mid = flat[127:64];
        res.hi  = flat[159:128];
        return res;
    endfunction

endpackage

// File: hdl/kvs_cell.sv
// One table cell: holds a key and value, compares and updates the passing transaction
module kvs_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  kvs_pkg::t_token i_tok,
    output logic            o_valid,
    output kvs_pkg::t_token o_tok,
    output logic            o_used
);
    import kvs_pkg::*;

    logic               r_valid;
    t_token             r_tok;
    logic               r_used;
    t_key               r_key;
    logic signed [63:0] r_value;

    t_token n_tok;
    logic   match;
    logic   hit;
    logic   wr;

    always_comb begin
        match = r_used && (r_key == i_tok.key);
        hit   = i_valid && !i_tok.done &&
                (match || (i_tok.op == OP_SET && !r_used));
        wr    = i_adv && hit && i_tok.op == OP_SET;
        n_tok = i_tok;
        if (hit) begin
            n_tok.done = 1'b1;
            n_tok.ok   = 1'b1;
            if (i_tok.op == OP_GET) begin
                n_tok.data = r_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_used  <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            if (wr) begin
                r_used <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
        end
        if (wr) begin
            r_key   <= i_tok.key;
            r_value <= i_tok.data;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_used  = r_used;

endmodule

// File: hdl/keyed_value_store.sv
// A transaction passes through the register of each cell in turn and then the output register.
// Throughput: one transaction per cycle while the output is not stalled; requests walk the
// cell chain one cell a cycle, so a later transaction always sees the updates of earlier ones.
// Reset: synchronous, active low; marks every cell free and empties the chain, no sweep.
// The whole chain holds while a result waits on a stalled output.
module keyed_value_store #(
    parameter int ENTRIES   = 128,
    parameter int KEY_BYTES = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kvs_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kvs_pkg::t_out_item o_out_data
);
    import kvs_pkg::*;

    `include "assert_macros.svh"

    logic   adv;
    logic   tok_valid [ENTRIES+1];
    t_token tok       [ENTRIES+1];
    logic   used      [ENTRIES];
    t_key   raw_key;

    logic      r_out_valid;
    t_out_item r_out;

    assign adv = !r_out_valid || !i_out_stall;

    always_comb begin
        raw_key.lo  = i_in_data.key_bytes_low;
        raw_key.mid = i_in_data.key_bytes_mid;
        raw_key.hi  = i_in_data.key_bytes_high;
        tok_valid[0] = i_in_valid;
        tok[0].op    = i_in_data.opcode;
        tok[0].key   = normalize_key(raw_key, KEY_BYTES);
        tok[0].done  = (tok[0].key.lo[7:0] == 8'h00);
        tok[0].ok    = 1'b0;
        tok[0].data  = (i_in_data.opcode == OP_SET) ? i_in_data.store_value : 64'sd0;
    end

    for (genvar c = 0; c < ENTRIES; c++) begin : g_cell
        kvs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (tok_valid[c]),
            .i_tok   (tok[c]),
            .o_valid (tok_valid[c+1]),
            .o_tok   (tok[c+1]),
            .o_used  (used[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= tok_valid[ENTRIES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && tok_valid[ENTRIES]) begin
            r_out.success    <= tok[ENTRIES].ok;
            r_out.read_value <= (tok[ENTRIES].op == OP_GET) ? tok[ENTRIES].data : 64'sd0;
        end
    end

    assign o_in_stall  = !adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_IMPLIES(a_stall_follows_out, i_clk, i_rst_n, 1'b1,
        o_in_stall == (o_out_valid && i_out_stall))
    `ASSERT_IMPLIES(a_ok_means_done, i_clk, i_rst_n,
        tok_valid[ENTRIES] && tok[ENTRIES].ok, tok[ENTRIES].done)
    `ASSERT_IMPLIES(a_set_fail_only_when_full, i_clk, i_rst_n,
        tok_valid[ENTRIES] && tok[ENTRIES].op == OP_SET && !tok[ENTRIES].ok &&
        tok[ENTRIES].key.lo[7:0] != 8'h00, used[ENTRIES-1])

endmodule
